>>> hw/rtl/irla_pkg.sv
`default_nettype none
package irla_pkg;

  localparam int SENSOR_W   = 2;
  localparam int SAMPLE_W   = 10;
  localparam int DIST_W     = 17;
  localparam int VOLT_W     = 16;
  localparam int CDIST_W    = 14;
  localparam int CIDX_W     = 5;

  localparam int SHORT_POINTS = 18;
  localparam int LONG_POINTS  = 15;

  localparam logic [DIST_W-1:0] SHORT_SENTINEL = 17'd1;
  localparam logic [DIST_W-1:0] LONG_SENTINEL  = 17'd92000;
  // largest in-chart result: 150.00 cm in hundredths of an inch
  localparam logic [DIST_W-1:0] MAX_IN_CHART   = 17'd5905;

  localparam int MV_PER_COUNT = 49;   // 0.1 mV units per converter count
  localparam int SCALE_NUM    = 100;
  localparam int SCALE_DEN    = 254;

  // restoring divider for the interpolation: quotient always fits QUO_W bits
  localparam int QUO_W  = 17;
  localparam int DIVD_W = 34;
  localparam int DVS_W  = 21;
  localparam int TOT_W  = 27;

  localparam int WINDOW_LEN_DEF   = 10;
  localparam int SENSOR_COUNT_DEF = 4;

  localparam logic [CIDX_W-1:0] SHORT_LAST = 5'd17;
  localparam logic [CIDX_W-1:0] LONG_LAST  = 5'd14;

  function automatic logic [VOLT_W-1:0] chart_volt(input logic is_long,
                                                   input logic [CIDX_W-1:0] idx);
    logic [VOLT_W-1:0] r;
    r = '0;
    if (is_long) begin
      case (idx)
        5'd0:  r = 16'd27500;
        5'd1:  r = 16'd25100;
        5'd2:  r = 16'd20000;
        5'd3:  r = 16'd15100;
        5'd4:  r = 16'd12500;
        5'd5:  r = 16'd10500;
        5'd6:  r = 16'd9000;
        5'd7:  r = 16'd8000;
        5'd8:  r = 16'd7000;
        5'd9:  r = 16'd6500;
        5'd10: r = 16'd6000;
        5'd11: r = 16'd5500;
        5'd12: r = 16'd5000;
        5'd13: r = 16'd4900;
        5'd14: r = 16'd4600;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        5'd0:  r = 16'd30400;
        5'd1:  r = 16'd30100;
        5'd2:  r = 16'd27500;
        5'd3:  r = 16'd23700;
        5'd4:  r = 16'd20100;
        5'd5:  r = 16'd17800;
        5'd6:  r = 16'd15700;
        5'd7:  r = 16'd14000;
        5'd8:  r = 16'd12700;
        5'd9:  r = 16'd10600;
        5'd10: r = 16'd9300;
        5'd11: r = 16'd8100;
        5'd12: r = 16'd7400;
        5'd13: r = 16'd6500;
        5'd14: r = 16'd5300;
        5'd15: r = 16'd4200;
        5'd16: r = 16'd3800;
        5'd17: r = 16'd3000;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [CDIST_W-1:0] chart_dist(input logic is_long,
                                                    input logic [CIDX_W-1:0] idx);
    logic [CDIST_W-1:0] r;
    r = '0;
    if (is_long) begin
      case (idx)
        5'd0:  r = 14'd1000;
        5'd1:  r = 14'd2000;
        5'd2:  r = 14'd3000;
        5'd3:  r = 14'd4000;
        5'd4:  r = 14'd5000;
        5'd5:  r = 14'd6000;
        5'd6:  r = 14'd7000;
        5'd7:  r = 14'd8000;
        5'd8:  r = 14'd9000;
        5'd9:  r = 14'd10000;
        5'd10: r = 14'd11000;
        5'd11: r = 14'd12000;
        5'd12: r = 14'd13000;
        5'd13: r = 14'd14000;
        5'd14: r = 14'd15000;
        default: r = '0;
      endcase
    end else begin
      case (idx)
        5'd0:  r = 14'd290;
        5'd1:  r = 14'd350;
        5'd2:  r = 14'd400;
        5'd3:  r = 14'd490;
        5'd4:  r = 14'd600;
        5'd5:  r = 14'd700;
        5'd6:  r = 14'd800;
        5'd7:  r = 14'd900;
        5'd8:  r = 14'd1000;
        5'd9:  r = 14'd1200;
        5'd10: r = 14'd1400;
        5'd11: r = 14'd1600;
        5'd12: r = 14'd1800;
        5'd13: r = 14'd2000;
        5'd14: r = 14'd2500;
        5'd15: r = 14'd3000;
        5'd16: r = 14'd3500;
        5'd17: r = 14'd4000;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ir_range_linearize_and_average.sv
// From the accepting edge to out_valid: the search walks the chart one segment a cycle. Inside the
// chart two multiply steps, scaling and a 17-step divide follow; an out-of-range sample goes
// straight to the window step, which fills the window on a sensor's first sample, on later ones
// reads, updates and takes the mean, and is skipped for a sensor without a window.
// One word at a time: a new sample is accepted only in the idle state.
// Reset (rst, synchronous): clears window-filled flags and heads, drops out_valid, sets long_idx to 3.
`default_nettype none
module ir_range_linearize_and_average
  import irla_pkg::*;
#(
  parameter int WINDOW_LEN   = WINDOW_LEN_DEF,
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [SENSOR_W-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SENSOR_W-1:0] sensor,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [DIST_W-1:0]        distance,
  output logic                     out_of_range,
  output logic [DIST_W-1:0]        window_average
);

  localparam int SEN_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int HEAD_W  = $clog2(WINDOW_LEN);
  localparam int DEPTH   = SENSOR_COUNT * WINDOW_LEN;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SUM_W   = DIST_W + $clog2(WINDOW_LEN);
  localparam int DCNT_W  = $clog2(QUO_W);
  // mean by reciprocal multiplication, exact for any SUM_W-bit sum
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW_LEN);
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_MUL_A, S_MUL_B, S_SCALE, S_DIV,
    S_WIN, S_FILL, S_UPDATE, S_AVG, S_DONE
  } state_t;

  state_t state;

  logic [SENSOR_W-1:0] long_idx;
  logic                is_long;
  logic                oor;
  logic                in_win;
  logic [SEN_W-1:0]    sidx;
  logic [ADDR_W-1:0]   win_base;
  logic [VOLT_W-1:0]   volt;
  logic [CIDX_W-1:0]   cidx;

  logic [VOLT_W-1:0]   den;
  logic [VOLT_W-1:0]   vdiff;
  logic [CDIST_W-1:0]  dt_lo;
  logic [CDIST_W-1:0]  ddiff;
  logic [TOT_W-1:0]    tot;
  logic [DIST_W-1:0]   lin_dist;
  logic [DIST_W-1:0]   avg;

  logic [DVS_W-1:0]    rem;
  logic [QUO_W-1:0]    q_sh;
  logic [DVS_W-1:0]    divisor;
  logic [DCNT_W-1:0]   div_cnt;

  logic [HEAD_W-1:0]   fill_cnt;
  logic                filled [SENSOR_COUNT];
  logic [HEAD_W-1:0]   head   [SENSOR_COUNT];
  logic [SUM_W-1:0]    sum    [SENSOR_COUNT];

  logic [DIST_W-1:0]   mem [DEPTH];
  logic [DIST_W-1:0]   mem_rdata;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;

  // combinational helpers
  logic [VOLT_W-1:0]   volt_in;
  logic                long_in;
  logic                oor_in;
  logic [VOLT_W-1:0]   vt_cur;
  logic [VOLT_W-1:0]   vt_nxt;
  logic [CDIST_W-1:0]  dt_cur;
  logic [CDIST_W-1:0]  dt_nxt;
  logic [TOT_W-1:0]    prod_a;
  logic [TOT_W-1:0]    prod_b;
  logic [DIVD_W-1:0]   num_scaled;
  logic [DVS_W-1:0]    dvs_scaled;
  logic [DVS_W:0]      trial;
  logic                q_bit;
  logic [DVS_W:0]      trial_sub;
  logic [SUM_W-1:0]    sum_new;
  logic [PROD_W-1:0]   avg_prod;
  logic                out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    volt_in = VOLT_W'(sample) * VOLT_W'(MV_PER_COUNT);
    long_in = (sensor == long_idx);
    oor_in  = (volt_in > chart_volt(long_in, '0)) ||
              (volt_in < chart_volt(long_in, long_in ? LONG_LAST : SHORT_LAST));
    vt_cur  = chart_volt(is_long, cidx);
    vt_nxt  = chart_volt(is_long, cidx + 1'b1);
    dt_cur  = chart_dist(is_long, cidx);
    dt_nxt  = chart_dist(is_long, cidx + 1'b1);
    prod_a  = TOT_W'(dt_lo) * TOT_W'(den);
    prod_b  = TOT_W'(vdiff) * TOT_W'(ddiff);
    num_scaled = DIVD_W'(tot) * DIVD_W'(SCALE_NUM);
    dvs_scaled = DVS_W'(den) * DVS_W'(SCALE_DEN);
    trial     = {rem, q_sh[QUO_W-1]};
    q_bit     = (trial >= {1'b0, divisor});
    trial_sub = trial - {1'b0, divisor};
    sum_new   = sum[sidx] - SUM_W'(mem_rdata) + SUM_W'(lin_dist);
    avg_prod  = {{RECIP_W{1'b0}}, sum[sidx]} * {{SUM_W{1'b0}}, AVG_RECIP};
  end

  // window store: one write port, one registered read port
  always_comb begin
    mem_we    = (state == S_FILL) || (state == S_UPDATE);
    mem_raddr = win_base + ADDR_W'(head[sidx]);
    mem_waddr = (state == S_FILL) ? (win_base + ADDR_W'(fill_cnt)) : mem_raddr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= lin_dist;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      long_idx  <= 2'd3;
      out_valid <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        filled[i] <= 1'b0;
        head[i]   <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        long_idx <= cfg_data;
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            volt     <= volt_in;
            is_long  <= long_in;
            oor      <= oor_in;
            in_win   <= (int'(sensor) < SENSOR_COUNT);
            sidx     <= SEN_W'(sensor);
            win_base <= ADDR_W'(int'(sensor) * WINDOW_LEN);
            cidx     <= '0;
            state    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (oor) begin
            lin_dist <= is_long ? LONG_SENTINEL : SHORT_SENTINEL;
            state    <= S_WIN;
          end else if (volt >= vt_nxt) begin
            den   <= vt_cur - vt_nxt;
            vdiff <= vt_cur - volt;
            dt_lo <= dt_cur;
            ddiff <= dt_nxt - dt_cur;
            state <= S_MUL_A;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        S_MUL_A: begin
          tot   <= prod_a;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          tot   <= tot + prod_b;
          state <= S_SCALE;
        end
        S_SCALE: begin
          rem     <= DVS_W'(num_scaled[DIVD_W-1:QUO_W]);
          q_sh    <= num_scaled[QUO_W-1:0];
          divisor <= dvs_scaled;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= q_bit ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
          q_sh    <= {q_sh[QUO_W-2:0], q_bit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DCNT_W'(QUO_W - 1)) begin
            lin_dist <= {q_sh[QUO_W-2:0], q_bit};
            state    <= S_WIN;
          end
        end
        S_WIN: begin
          if (!in_win) begin
            avg   <= '0;
            state <= S_DONE;
          end else if (!filled[sidx]) begin
            fill_cnt <= '0;
            state    <= S_FILL;
          end else begin
            // read of the oldest word issued here, data arrives next cycle
            state <= S_UPDATE;
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == HEAD_W'(WINDOW_LEN - 1)) begin
            filled[sidx] <= 1'b1;
            head[sidx]   <= '0;
            sum[sidx]    <= SUM_W'(lin_dist * WINDOW_LEN);
            avg          <= lin_dist;
            state        <= S_DONE;
          end
        end
        S_UPDATE: begin
          sum[sidx]  <= sum_new;
          head[sidx] <= (head[sidx] == HEAD_W'(WINDOW_LEN - 1)) ? '0 : head[sidx] + 1'b1;
          state      <= S_AVG;
        end
        S_AVG: begin
          avg   <= avg_prod[AVG_SHIFT +: DIST_W];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            distance       <= lin_dist;
            out_of_range   <= oor;
            window_average <= avg;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/irla_checker.sv
`default_nettype none
module irla_checker
  import irla_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DIST_W-1:0] distance,
  input wire logic              out_of_range
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(out_of_range))
    else $error("result word changed while stalled");

  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> distance == SHORT_SENTINEL || distance == LONG_SENTINEL)
    else $error("out-of-range word without sentinel distance");

  a_in_chart: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> distance <= MAX_IN_CHART)
    else $error("in-chart distance beyond chart end");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ir_range_linearize_and_average irla_checker u_irla_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .distance     (distance),
  .out_of_range (out_of_range)
);
`default_nettype wire
